@@ sv/scsr_pkg.sv @@
package scsr_pkg;

  // Command codes carried in in_tuser
  typedef enum logic [2:0] {
    CMD_INS_P  = 3'd0,
    CMD_INS_S  = 3'd1,
    CMD_SWAP   = 3'd2,
    CMD_LIST_P = 3'd3,
    CMD_LIST_S = 3'd4
  } cmd_t;

  // Result status codes carried in out_tuser
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_NOCAND = 2'd3
  } status_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_WALK_START,
    OP_INS_A,
    OP_INS_B,
    OP_CLK_CLEAR,
    OP_SEC_START,
    OP_SEC_NEXT,
    OP_EXCHANGE,
    OP_LIST_NEXT
  } dp_op_t;

  // Source of a result item
  typedef enum logic [1:0] {
    OUT_STATUS,
    OUT_ENTRY,
    OUT_VICTIM
  } out_sel_t;

  // Controller to datapath
  typedef struct packed {
    dp_op_t   op;
    logic     rd_en;      // read both stores this cycle
    logic     rd_hand;    // primary read at the hand instead of the walk pointer
    logic     out_load;   // load the output register
    out_sel_t out_sel;
    status_t  out_status;
    logic     out_last;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic p_empty;
    logic s_empty;
    logic sel_empty;
    logic sel_full;
    logic rd_flag_p;
    logic rd_flag_s;
    logic clk_more;
    logic walk_last_s;
    logic walk_last_sel;
    logic out_free;
  } dp_stat_t;

endpackage

@@ sv/second_chance_swap_replacer.sv @@
// Two ring stores (primary, secondary) of CAPACITY entries of value and reference flag.
// in_tuser selects insert primary/secondary, swap, or list primary/secondary. An item is
// taken in one cycle and its results leave through a one-deep output register, so a new
// item may be taken while the last result still waits. An insert writes the new entry,
// links the old tail to it, then links it back to the head. A swap sweeps the primary
// ring from the hand, clearing set flags, then probes the secondary ring from its head
// for a clear flag and exchanges the two entries. A list reads its ring entry by entry;
// results wait for a free output register. Each command gives one result (status in
// out_tuser) except a list, which gives one per entry with out_tlast on the final one;
// command codes 5 to 7 are ignored and give no result. Entries are never read before they
// are written, so the memories need no clearing after reset.
module second_chance_swap_replacer
  import scsr_pkg::*;
#(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,    // [31:0] value, [32] ref_bit, rest zero
  input  logic [2:0]  in_tuser,    // [2:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // [31:0] value_res, [32] ref_bit_res, rest zero
  output logic [1:0]  out_tuser,   // [1:0] status
  output logic        out_tlast
);

  ctrl_cmd_t   ctl;
  dp_stat_t    stat;
  logic [31:0] res_value;
  logic        res_flag;

  scsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .ctl      (ctl)
  );

  scsr_datapath #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .stat       (stat),
    .in_cmd     (in_tuser),
    .in_value   (in_tdata[31:0]),
    .in_ref     (in_tdata[32]),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_status (out_tuser),
    .out_value  (res_value),
    .out_flag   (res_flag),
    .out_last   (out_tlast)
  );

  assign out_tdata = {7'd0, res_flag, res_value};

endmodule

@@ sv/scsr_store.sv @@
// One ring store: entry memory (flag, value) and link memory, registered reads
module scsr_store
  import scsr_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int DW    = 33
) (
  input  logic                     clk,
  input  logic                     d_we,
  input  logic [$clog2(DEPTH)-1:0] d_addr,
  input  logic [DW-1:0]            d_wdata,
  input  logic                     l_we,
  input  logic [$clog2(DEPTH)-1:0] l_addr,
  input  logic [$clog2(DEPTH)-1:0] l_wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rd_data,
  output logic [$clog2(DEPTH)-1:0] rd_link
);

  localparam int IDX_W = $clog2(DEPTH);

  logic [DW-1:0]    dmem [DEPTH];
  logic [IDX_W-1:0] lmem [DEPTH];

  // entry memory
  always_ff @(posedge clk) begin
    if (d_we) begin
      dmem[d_addr] <= d_wdata;
    end
    if (re) begin
      rd_data <= dmem[raddr];
    end
  end

  // link memory
  always_ff @(posedge clk) begin
    if (l_we) begin
      lmem[l_addr] <= l_wdata;
    end
    if (re) begin
      rd_link <= lmem[raddr];
    end
  end

endmodule

@@ sv/scsr_datapath.sv @@
// Pointers, counters, walk registers, both stores and the output register
module scsr_datapath
  import scsr_pkg::*;
#(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ctrl_cmd_t   ctl,
  output dp_stat_t    stat,
  input  logic [2:0]  in_cmd,
  input  logic [31:0] in_value,
  input  logic        in_ref,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_value,
  output logic        out_flag,
  output logic        out_last
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int DW    = VALUE_WIDTH + 1;

  // latched item
  cmd_t                   lat_cmd_r;
  logic [VALUE_WIDTH-1:0] lat_val_r;
  logic                   lat_ref_r;

  // ring pointers and counts
  logic [IDX_W-1:0] hand_r, ptail_r, shead_r, stail_r;
  logic [CNT_W-1:0] pcnt_r, scnt_r;

  // walk state and victim
  logic [IDX_W-1:0]       w_r;
  logic [CNT_W-1:0]       i_r;
  logic [VALUE_WIDTH-1:0] vic_val_r;
  logic                   vic_flag_r;

  // output register
  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic [31:0] out_value_r;
  logic        out_flag_r;
  logic        out_last_r;

  // store ports
  logic             p_d_we, s_d_we, p_l_we, s_l_we;
  logic [IDX_W-1:0] p_d_addr, s_d_addr, l_addr, l_wdata, p_raddr;
  logic [DW-1:0]    p_d_wdata, s_d_wdata, p_rd, s_rd;
  logic [IDX_W-1:0] p_rd_link, s_rd_link;

  logic                   sel_sec;
  logic [IDX_W-1:0]       sel_head, sel_tail, cnt_idx;
  logic [CNT_W-1:0]       sel_cnt;
  logic [VALUE_WIDTH-1:0] p_rd_val, s_rd_val;
  logic                   out_free;
  logic [31:0]            out_value_nxt;
  logic                   out_flag_nxt;

  assign sel_sec  = (lat_cmd_r == CMD_INS_S) || (lat_cmd_r == CMD_LIST_S);
  assign sel_head = sel_sec ? shead_r : hand_r;
  assign sel_tail = sel_sec ? stail_r : ptail_r;
  assign sel_cnt  = sel_sec ? scnt_r : pcnt_r;
  assign cnt_idx  = sel_cnt[IDX_W-1:0];
  assign p_rd_val = p_rd[VALUE_WIDTH-1:0];
  assign s_rd_val = s_rd[VALUE_WIDTH-1:0];
  assign p_raddr  = ctl.rd_hand ? hand_r : w_r;
  assign out_free = !out_valid_r || out_ready;

  scsr_store #(.DEPTH(CAPACITY), .DW(DW)) u_prim (
    .clk     (clk),
    .d_we    (p_d_we),
    .d_addr  (p_d_addr),
    .d_wdata (p_d_wdata),
    .l_we    (p_l_we),
    .l_addr  (l_addr),
    .l_wdata (l_wdata),
    .re      (ctl.rd_en),
    .raddr   (p_raddr),
    .rd_data (p_rd),
    .rd_link (p_rd_link)
  );

  scsr_store #(.DEPTH(CAPACITY), .DW(DW)) u_sec (
    .clk     (clk),
    .d_we    (s_d_we),
    .d_addr  (s_d_addr),
    .d_wdata (s_d_wdata),
    .l_we    (s_l_we),
    .l_addr  (l_addr),
    .l_wdata (l_wdata),
    .re      (ctl.rd_en),
    .raddr   (w_r),
    .rd_data (s_rd),
    .rd_link (s_rd_link)
  );

  // store write selection
  always_comb begin
    p_d_we    = 1'b0;
    s_d_we    = 1'b0;
    p_l_we    = 1'b0;
    s_l_we    = 1'b0;
    p_d_addr  = hand_r;
    s_d_addr  = w_r;
    p_d_wdata = {lat_ref_r, lat_val_r};
    s_d_wdata = {lat_ref_r, lat_val_r};
    l_addr    = sel_tail;
    l_wdata   = cnt_idx;
    case (ctl.op)
      OP_INS_A: begin
        // new entry, and link the old tail to it
        p_d_we   = !sel_sec;
        s_d_we   = sel_sec;
        p_d_addr = cnt_idx;
        s_d_addr = cnt_idx;
        p_l_we   = !sel_sec && (sel_cnt != '0);
        s_l_we   = sel_sec && (sel_cnt != '0);
      end
      OP_INS_B: begin
        // new entry points back at the head (itself when first)
        p_l_we  = !sel_sec;
        s_l_we  = sel_sec;
        l_addr  = cnt_idx;
        l_wdata = (sel_cnt == '0) ? '0 : sel_head;
      end
      OP_CLK_CLEAR: begin
        p_d_we    = 1'b1;
        p_d_wdata = {1'b0, p_rd_val};
      end
      OP_EXCHANGE: begin
        p_d_we    = 1'b1;
        p_d_wdata = {1'b1, s_rd_val};
        s_d_we    = 1'b1;
        s_d_wdata = {1'b0, vic_val_r};
      end
      default: begin
      end
    endcase
  end

  // ring pointers and counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hand_r  <= '0;
      ptail_r <= '0;
      pcnt_r  <= '0;
      shead_r <= '0;
      stail_r <= '0;
      scnt_r  <= '0;
    end else begin
      case (ctl.op)
        OP_INS_B: begin
          if (sel_sec) begin
            stail_r <= cnt_idx;
            scnt_r  <= scnt_r + CNT_W'(1);
            if (scnt_r == '0) begin
              shead_r <= '0;
            end
          end else begin
            ptail_r <= cnt_idx;
            pcnt_r  <= pcnt_r + CNT_W'(1);
            if (pcnt_r == '0) begin
              hand_r <= '0;
            end
          end
        end
        OP_CLK_CLEAR: begin
          ptail_r <= hand_r;
          hand_r  <= p_rd_link;
        end
        default: begin
        end
      endcase
    end
  end

  // item latch, walk pointer, step count, victim
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LATCH: begin
        lat_cmd_r <= cmd_t'(in_cmd);
        lat_val_r <= VALUE_WIDTH'($signed(in_value));
        lat_ref_r <= in_ref;
      end
      OP_WALK_START: begin
        w_r <= sel_head;
        i_r <= '0;
      end
      OP_CLK_CLEAR: begin
        i_r <= i_r + CNT_W'(1);
      end
      OP_SEC_START: begin
        w_r        <= shead_r;
        i_r        <= '0;
        vic_val_r  <= p_rd_val;
        vic_flag_r <= p_rd[VALUE_WIDTH];
      end
      OP_SEC_NEXT: begin
        w_r <= s_rd_link;
        i_r <= i_r + CNT_W'(1);
      end
      OP_LIST_NEXT: begin
        w_r <= sel_sec ? s_rd_link : p_rd_link;
        i_r <= i_r + CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // result payload selection
  always_comb begin
    case (ctl.out_sel)
      OUT_ENTRY: begin
        out_value_nxt = sel_sec ? 32'(s_rd_val) : 32'(p_rd_val);
        out_flag_nxt  = sel_sec ? s_rd[VALUE_WIDTH] : p_rd[VALUE_WIDTH];
      end
      OUT_VICTIM: begin
        out_value_nxt = 32'(vic_val_r);
        out_flag_nxt  = vic_flag_r;
      end
      default: begin
        out_value_nxt = '0;
        out_flag_nxt  = 1'b0;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_status_r <= ctl.out_status;
      out_value_r  <= out_value_nxt;
      out_flag_r   <= out_flag_nxt;
      out_last_r   <= ctl.out_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;
  assign out_flag   = out_flag_r;
  assign out_last   = out_last_r;

  // status to the controller
  assign stat.cmd           = lat_cmd_r;
  assign stat.p_empty       = (pcnt_r == '0);
  assign stat.s_empty       = (scnt_r == '0);
  assign stat.sel_empty     = (sel_cnt == '0);
  assign stat.sel_full      = (sel_cnt == CNT_W'(CAPACITY));
  assign stat.rd_flag_p     = p_rd[VALUE_WIDTH];
  assign stat.rd_flag_s     = s_rd[VALUE_WIDTH];
  assign stat.clk_more      = (i_r < pcnt_r);
  assign stat.walk_last_s   = ((i_r + CNT_W'(1)) == scnt_r);
  assign stat.walk_last_sel = ((i_r + CNT_W'(1)) == sel_cnt);
  assign stat.out_free      = out_free;

endmodule

@@ sv/scsr_ctrl.sv @@
// Command sequencer: insert, clock sweep plus secondary search, list walk
module scsr_ctrl
  import scsr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t ctl
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_B,
    S_SW_PRD,
    S_SW_PCHK,
    S_SW_SRD,
    S_SW_SCHK,
    S_LIST_RD,
    S_LIST_OUT,
    S_EMIT_ST,
    S_EMIT_VIC
  } state_t;

  state_t  state_r, state_nxt;
  status_t st_r, st_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_nxt      = state_r;
    st_nxt         = st_r;
    ctl.op         = OP_NONE;
    ctl.rd_en      = 1'b0;
    ctl.rd_hand    = 1'b0;
    ctl.out_load   = 1'b0;
    ctl.out_sel    = OUT_STATUS;
    ctl.out_status = st_r;
    ctl.out_last   = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.op    = OP_LATCH;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.cmd)
          CMD_INS_P, CMD_INS_S: begin
            if (stat.sel_full) begin
              st_nxt    = ST_FULL;
              state_nxt = S_EMIT_ST;
            end else begin
              ctl.op    = OP_INS_A;
              st_nxt    = ST_OK;
              state_nxt = S_INS_B;
            end
          end
          CMD_SWAP: begin
            if (stat.p_empty || stat.s_empty) begin
              st_nxt    = ST_EMPTY;
              state_nxt = S_EMIT_ST;
            end else begin
              ctl.op    = OP_WALK_START;
              state_nxt = S_SW_PRD;
            end
          end
          CMD_LIST_P, CMD_LIST_S: begin
            if (stat.sel_empty) begin
              st_nxt    = ST_EMPTY;
              state_nxt = S_EMIT_ST;
            end else begin
              ctl.op    = OP_WALK_START;
              state_nxt = S_LIST_RD;
            end
          end
          default: begin
            // unused codes give no result
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_INS_B: begin
        ctl.op    = OP_INS_B;
        state_nxt = S_EMIT_ST;
      end
      S_SW_PRD: begin
        ctl.rd_en   = 1'b1;
        ctl.rd_hand = 1'b1;
        state_nxt   = S_SW_PCHK;
      end
      S_SW_PCHK: begin
        // second chance: clear and move on while the flag is set and sweep steps remain
        if (stat.rd_flag_p && stat.clk_more) begin
          ctl.op    = OP_CLK_CLEAR;
          state_nxt = S_SW_PRD;
        end else begin
          ctl.op    = OP_SEC_START;
          state_nxt = S_SW_SRD;
        end
      end
      S_SW_SRD: begin
        ctl.rd_en = 1'b1;
        state_nxt = S_SW_SCHK;
      end
      S_SW_SCHK: begin
        if (!stat.rd_flag_s) begin
          ctl.op    = OP_EXCHANGE;
          state_nxt = S_EMIT_VIC;
        end else if (stat.walk_last_s) begin
          st_nxt    = ST_NOCAND;
          state_nxt = S_EMIT_ST;
        end else begin
          ctl.op    = OP_SEC_NEXT;
          state_nxt = S_SW_SRD;
        end
      end
      S_LIST_RD: begin
        ctl.rd_en = 1'b1;
        state_nxt = S_LIST_OUT;
      end
      S_LIST_OUT: begin
        ctl.out_sel    = OUT_ENTRY;
        ctl.out_status = ST_OK;
        ctl.out_last   = stat.walk_last_sel;
        if (stat.out_free) begin
          ctl.out_load = 1'b1;
          ctl.op       = OP_LIST_NEXT;
          state_nxt    = stat.walk_last_sel ? S_IDLE : S_LIST_RD;
        end
      end
      S_EMIT_ST: begin
        if (stat.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_EMIT_VIC: begin
        ctl.out_sel    = OUT_VICTIM;
        ctl.out_status = ST_OK;
        if (stat.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and status code
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

endmodule
